// ----- rtl/comparator_output_set_update_macros.svh -----
// Assertion macros shared by the comparator output set update RTL.
// Included by modules that check their own control logic; no other dependencies.
`ifndef COMPARATOR_OUTPUT_SET_UPDATE_MACROS_SVH
`define COMPARATOR_OUTPUT_SET_UPDATE_MACROS_SVH

`ifndef SYNTHESIS

// Checks that a condition holds at every clock edge out of reset.
`define COSU_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("cosu assertion failed");

// Checks that a trigger is followed by a condition in the next cycle.
`define COSU_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("cosu assertion failed");

`else

`define COSU_ASSERT(label, cond)
`define COSU_ASSERT_NEXT(label, trig, cond)

`endif

`endif

// ----- rtl/cosu_pkg.sv -----
// Package for the comparator output set update block: sizes, codes, types
// and small helper functions. No dependencies.
package cosu_pkg;

    // Number of wires of the comparator network.
    localparam int CHANNELS = 8;
    localparam int LEVELS   = CHANNELS - 1;
    localparam int MAP_SIZE = 1 << CHANNELS;
    localparam int POP_W    = $clog2(CHANNELS + 1);
    localparam int IDX_W    = $clog2(LEVELS);

    typedef logic [CHANNELS-1:0] wire_t;
    typedef logic [POP_W-1:0]    pop_t;
    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [CHANNELS-1:0] cnt_t;

    localparam wire_t MAP_LAST  = '1;
    localparam idx_t  LVL_LAST  = idx_t'(LEVELS - 1);

    // Input kind codes.
    localparam logic KIND_COMPARE = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // What one sweep over the presence map does to each entry.
    typedef enum logic [1:0] {
        MODE_INIT,
        MODE_PASS,
        MODE_SWAP
    } mode_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_DRAIN,
        ST_IDLE,
        ST_EMIT
    } state_t;

    // Control of the sweep unit for the entry whose read data is returning.
    typedef struct packed {
        logic  clr;
        logic  vld;
        mode_t mode;
        wire_t addr;
        wire_t cm;
        wire_t hi;
        wire_t lo;
    } sweep_ctrl_t;

    // Per-level statistics gathered during a sweep.
    typedef struct packed {
        cnt_t  cnt;
        wire_t orp;
        wire_t orl;
        logic  moved;
    } lvl_stats_t;

    function automatic pop_t popcount(input wire_t x);
        pop_t n;
        n = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            n = n + pop_t'(x[i]);
        end
        return n;
    endfunction

    // Presence of a vector after reset: between one and CHANNELS-1 ones.
    function automatic logic reset_present(input wire_t x);
        pop_t n;
        n = popcount(x);
        return (n != '0) && (n <= pop_t'(LEVELS));
    endfunction

endpackage

// ----- rtl/cosu_ram.sv -----
// Generic RAM with one write port and two registered read ports.
// Standalone; no package dependencies.
module cosu_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered reads.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- rtl/cosu_sweep.sv -----
// Sweep unit: updates one presence map entry per cycle and gathers
// per-level statistics. Depends on cosu_pkg.
module cosu_sweep (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cosu_pkg::sweep_ctrl_t ctrl,
    input  logic                 rd_self,
    input  logic                 rd_pair,
    input  cosu_pkg::idx_t       lvl_sel,
    output logic                 wr_en,
    output cosu_pkg::wire_t      wr_addr,
    output logic                 wr_data,
    output cosu_pkg::lvl_stats_t stats
);

    cosu_pkg::pop_t  pop;
    cosu_pkg::idx_t  hit_idx;
    logic            in_range;
    logic            has_hi;
    logic            has_lo;
    logic            new_val;
    logic            moved;

    cosu_pkg::cnt_t  cnt_reg  [cosu_pkg::LEVELS];
    cosu_pkg::cnt_t  cnt_next [cosu_pkg::LEVELS];
    cosu_pkg::wire_t orp_reg  [cosu_pkg::LEVELS];
    cosu_pkg::wire_t orp_next [cosu_pkg::LEVELS];
    cosu_pkg::wire_t orl_reg  [cosu_pkg::LEVELS];
    cosu_pkg::wire_t orl_next [cosu_pkg::LEVELS];
    logic            mov_reg  [cosu_pkg::LEVELS];
    logic            mov_next [cosu_pkg::LEVELS];

    // Classify the entry and compute its new presence bit.
    always_comb
    begin
        pop      = cosu_pkg::popcount(ctrl.addr);
        in_range = (pop != '0) && (pop <= cosu_pkg::pop_t'(cosu_pkg::LEVELS));
        hit_idx  = cosu_pkg::idx_t'(pop - cosu_pkg::pop_t'(1));
        has_hi   = |(ctrl.addr & ctrl.hi);
        has_lo   = |(ctrl.addr & ctrl.lo);
        moved    = 1'b0;
        case (ctrl.mode)
            cosu_pkg::MODE_INIT:
            begin
                new_val = in_range;
            end
            cosu_pkg::MODE_SWAP:
            begin
                if (has_hi && !has_lo)
                begin
                    // The vector leaves for its swapped image below it.
                    new_val = 1'b0;
                    moved   = rd_self;
                end
                else if (has_lo && !has_hi)
                begin
                    // The image merges with anything swapped into it.
                    new_val = rd_self | rd_pair;
                end
                else
                begin
                    new_val = rd_self;
                end
            end
            default:
            begin
                new_val = rd_self;
            end
        endcase
    end

    assign wr_en   = ctrl.vld;
    assign wr_addr = ctrl.addr;
    assign wr_data = new_val;

    // Per-level accumulators; each entry only looks at its own level.
    always_comb
    begin
        for (int i = 0; i < cosu_pkg::LEVELS; i++)
        begin
            cnt_next[i] = cnt_reg[i];
            orp_next[i] = orp_reg[i];
            orl_next[i] = orl_reg[i];
            mov_next[i] = mov_reg[i];
            if (ctrl.clr)
            begin
                cnt_next[i] = '0;
                orp_next[i] = '0;
                orl_next[i] = '0;
                mov_next[i] = 1'b0;
            end
            else if (ctrl.vld && in_range && (hit_idx == cosu_pkg::idx_t'(i)))
            begin
                if (new_val)
                begin
                    cnt_next[i] = cnt_reg[i] + cosu_pkg::cnt_t'(1);
                    orp_next[i] = orp_reg[i] | (~ctrl.addr & ctrl.cm);
                    orl_next[i] = orl_reg[i] | (ctrl.addr & ctrl.cm);
                end
                mov_next[i] = mov_reg[i] | moved;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cosu_pkg::LEVELS; i++)
            begin
                cnt_reg[i] <= '0;
                orp_reg[i] <= '0;
                orl_reg[i] <= '0;
                mov_reg[i] <= 1'b0;
            end
        end
        else
        begin
            for (int i = 0; i < cosu_pkg::LEVELS; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
                orp_reg[i] <= orp_next[i];
                orl_reg[i] <= orl_next[i];
                mov_reg[i] <= mov_next[i];
            end
        end
    end

    // Statistics of the level being reported.
    assign stats.cnt   = cnt_reg[lvl_sel];
    assign stats.orp   = orp_reg[lvl_sel];
    assign stats.orl   = orl_reg[lvl_sel];
    assign stats.moved = mov_reg[lvl_sel];

endmodule

// ----- rtl/comparator_output_set_update.sv -----
// Top level of the comparator output set update block: sequencer, P/L masks
// and result register. Depends on cosu_pkg, cosu_ram, cosu_sweep and the macro header.
//
// Usage:
// The input channel (in_valid, in_stall, kind, comparator_mask) takes one
// transaction per item: a comparator to apply or a restart. The output channel
// (out_valid, out_stall, level ... last) returns CHANNELS-1 result
// transactions per item, lowest level first, with last set on the final one.
// Each item is handled by a sweep over all 2^CHANNELS presence map entries,
// one entry per cycle through the shared update unit and a two-read-port RAM,
// then by the drain state and the emit state, which loads one result per level,
// and the block returns to idle, where the next item is taken. in_stall stays
// high from acceptance until the last result has been loaded into the output
// register; the next item may be accepted while that last result still waits.
// After reset the block runs an initialization sweep and a drain with in_stall
// high, writing the full input set. A restart item runs the same sweep and then
// reports the reset state. When the receiver stalls, the current result holds
// and the sequencer waits.
`include "comparator_output_set_update_macros.svh"

module comparator_output_set_update (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic [7:0] comparator_mask,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] level,
    output logic [6:0] distinct_count,
    output logic [7:0] p_mask,
    output logic [3:0] p_count,
    output logic [7:0] l_mask,
    output logic [3:0] l_count,
    output logic       changed,
    output logic       rejected,
    output logic       last
);

    cosu_pkg::state_t     state_reg, state_next;
    cosu_pkg::wire_t      addr_reg, addr_next;
    cosu_pkg::mode_t      mode_reg, mode_next;
    cosu_pkg::wire_t      cm_reg, cm_next;
    cosu_pkg::wire_t      lo_reg, lo_next;
    cosu_pkg::wire_t      hi_reg, hi_next;
    logic                 rej_reg, rej_next;
    logic                 emit_reg, emit_next;
    logic                 s1_vld_reg;
    cosu_pkg::wire_t      s1_addr_reg;
    cosu_pkg::idx_t       lvl_reg, lvl_next;

    cosu_pkg::wire_t      p_masks_reg [cosu_pkg::LEVELS];
    cosu_pkg::wire_t      l_masks_reg [cosu_pkg::LEVELS];

    logic                 out_vld_reg, out_vld_next;
    logic [2:0]           level_reg;
    logic [6:0]           dcount_reg;
    logic [7:0]           pmask_reg;
    logic [3:0]           pcount_reg;
    logic [7:0]           lmask_reg;
    logic [3:0]           lcount_reg;
    logic                 changed_reg;
    logic                 rejected_reg;
    logic                 last_reg;

    logic                 in_fire;
    logic                 out_load;
    cosu_pkg::wire_t      cm_in;
    cosu_pkg::wire_t      lo_in;
    cosu_pkg::sweep_ctrl_t sweep_ctrl;
    cosu_pkg::lvl_stats_t stats;
    logic                 rd_self;
    logic                 rd_pair;
    logic                 wr_en;
    cosu_pkg::wire_t      wr_addr;
    logic                 wr_data;
    cosu_pkg::wire_t      old_p;
    cosu_pkg::wire_t      old_l;
    cosu_pkg::wire_t      new_p;
    cosu_pkg::wire_t      new_l;

    assign in_stall = (state_reg != cosu_pkg::ST_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_load = (state_reg == cosu_pkg::ST_EMIT) && (!out_vld_reg || !out_stall);

    // Comparator decode: lowest selected wire and the other one.
    assign cm_in = cosu_pkg::wire_t'(comparator_mask);
    assign lo_in = cm_in & (~cm_in + cosu_pkg::wire_t'(1));

    // Sequencer: item acceptance, map sweep, drain and result emission.
    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        mode_next  = mode_reg;
        cm_next    = cm_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        rej_next   = rej_reg;
        emit_next  = emit_reg;
        lvl_next   = lvl_reg;
        case (state_reg)
            cosu_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = cosu_pkg::ST_SWEEP;
                    addr_next  = '0;
                    lvl_next   = '0;
                    emit_next  = 1'b1;
                    cm_next    = cm_in;
                    lo_next    = lo_in;
                    hi_next    = cm_in ^ lo_in;
                    rej_next   = 1'b0;
                    if (kind == cosu_pkg::KIND_RESTART)
                    begin
                        mode_next = cosu_pkg::MODE_INIT;
                    end
                    else if (cosu_pkg::popcount(cm_in) == cosu_pkg::pop_t'(2))
                    begin
                        mode_next = cosu_pkg::MODE_SWAP;
                    end
                    else
                    begin
                        mode_next = cosu_pkg::MODE_PASS;
                        rej_next  = 1'b1;
                    end
                end
            end
            cosu_pkg::ST_SWEEP:
            begin
                addr_next = addr_reg + cosu_pkg::wire_t'(1);
                if (addr_reg == cosu_pkg::MAP_LAST)
                begin
                    state_next = cosu_pkg::ST_DRAIN;
                end
            end
            cosu_pkg::ST_DRAIN:
            begin
                state_next = emit_reg ? cosu_pkg::ST_EMIT : cosu_pkg::ST_IDLE;
            end
            cosu_pkg::ST_EMIT:
            begin
                if (out_load)
                begin
                    lvl_next = lvl_reg + cosu_pkg::idx_t'(1);
                    if (lvl_reg == cosu_pkg::LVL_LAST)
                    begin
                        state_next = cosu_pkg::ST_IDLE;
                        lvl_next   = '0;
                    end
                end
            end
            default:
            begin
                state_next = cosu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= cosu_pkg::ST_SWEEP;
            addr_reg   <= '0;
            mode_reg   <= cosu_pkg::MODE_INIT;
            emit_reg   <= 1'b0;
            lvl_reg    <= '0;
            s1_vld_reg <= 1'b0;
            rej_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            mode_reg   <= mode_next;
            emit_reg   <= emit_next;
            lvl_reg    <= lvl_next;
            s1_vld_reg <= (state_reg == cosu_pkg::ST_SWEEP);
            rej_reg    <= rej_next;
        end
    end

    // Comparator wires and the address whose read data returns next cycle.
    always_ff @(posedge clk)
    begin
        cm_reg      <= cm_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        s1_addr_reg <= addr_reg;
    end

    // Presence map; port b reads the swap partner of the swept entry.
    cosu_ram #(
        .WIDTH (1),
        .DEPTH (cosu_pkg::MAP_SIZE)
    ) u_map (
        .clk     (clk),
        .we      (wr_en),
        .waddr   (wr_addr),
        .wdata   (wr_data),
        .raddr_a (addr_reg),
        .raddr_b (addr_reg ^ cm_reg),
        .rdata_a (rd_self),
        .rdata_b (rd_pair)
    );

    always_comb
    begin
        sweep_ctrl.clr  = in_fire;
        sweep_ctrl.vld  = s1_vld_reg;
        sweep_ctrl.mode = mode_reg;
        sweep_ctrl.addr = s1_addr_reg;
        sweep_ctrl.cm   = cm_reg;
        sweep_ctrl.hi   = hi_reg;
        sweep_ctrl.lo   = lo_reg;
    end

    cosu_sweep u_sweep (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (sweep_ctrl),
        .rd_self (rd_self),
        .rd_pair (rd_pair),
        .lvl_sel (lvl_reg),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .stats   (stats)
    );

    // New P and L masks of the level being reported.
    always_comb
    begin
        old_p = p_masks_reg[lvl_reg];
        old_l = l_masks_reg[lvl_reg];
        case (mode_reg)
            cosu_pkg::MODE_INIT:
            begin
                new_p = '1;
                new_l = '1;
            end
            cosu_pkg::MODE_SWAP:
            begin
                new_p = (old_p & ~cm_reg) | (((old_p & cm_reg) != '0) ? stats.orp : '0);
                new_l = (old_l & ~cm_reg) | (((old_l & cm_reg) != '0) ? stats.orl : '0);
            end
            default:
            begin
                new_p = old_p;
                new_l = old_l;
            end
        endcase
    end

    // Mask store, committed one level at a time as results are loaded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cosu_pkg::LEVELS; i++)
            begin
                p_masks_reg[i] <= '1;
                l_masks_reg[i] <= '1;
            end
        end
        else if (out_load)
        begin
            p_masks_reg[lvl_reg] <= new_p;
            l_masks_reg[lvl_reg] <= new_l;
        end
    end

    // Output register: holds a result until the receiver takes it.
    always_comb
    begin
        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            level_reg    <= 3'(lvl_reg + cosu_pkg::idx_t'(1));
            dcount_reg   <= 7'(stats.cnt);
            pmask_reg    <= 8'(new_p);
            pcount_reg   <= 4'(cosu_pkg::popcount(new_p));
            lmask_reg    <= 8'(new_l);
            lcount_reg   <= 4'(cosu_pkg::popcount(new_l));
            changed_reg  <= stats.moved;
            rejected_reg <= rej_reg;
            last_reg     <= (lvl_reg == cosu_pkg::LVL_LAST);
        end
    end

    assign out_valid      = out_vld_reg;
    assign level          = level_reg;
    assign distinct_count = dcount_reg;
    assign p_mask         = pmask_reg;
    assign p_count        = pcount_reg;
    assign l_mask         = lmask_reg;
    assign l_count        = lcount_reg;
    assign changed        = changed_reg;
    assign rejected       = rejected_reg;
    assign last           = last_reg;

    // Map writes only happen during a sweep or the drain cycle after it.
    `COSU_ASSERT(a_write_in_sweep, !wr_en || (state_reg == cosu_pkg::ST_SWEEP) || (state_reg == cosu_pkg::ST_DRAIN))
    // An accepted item starts its sweep at the first map entry.
    `COSU_ASSERT_NEXT(a_sweep_start, in_fire, (state_reg == cosu_pkg::ST_SWEEP) && (addr_reg == '0))
    // Loading the highest level ends the item.
    `COSU_ASSERT_NEXT(a_last_ends, out_load && (lvl_reg == cosu_pkg::LVL_LAST), state_reg == cosu_pkg::ST_IDLE)
    // A refused comparator never reports a moved vector.
    `COSU_ASSERT(a_reject_unchanged, !(out_vld_reg && rejected_reg) || !changed_reg)

endmodule
